### rtl/pba_pkg.sv
// Package for the point bearing angle block: widths, quadrant codes and the
// CORDIC arctangent table. No dependencies.
`default_nettype none

package pba_pkg;

	localparam int COORD_WIDTH    = 16;
	localparam int ANGLE_WIDTH    = 16;
	localparam int ROTATION_STEPS = 16;

	localparam int STEPS           = (ROTATION_STEPS > 32) ? 32 : ROTATION_STEPS;
	localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
	localparam int CORDIC_WIDTH    = 64;
	localparam int SHIFT_UP        = 60 - COORD_WIDTH;
	localparam int HEAD_PAD        = CORDIC_WIDTH - 60;
	localparam int ACC_WIDTH       = 34;
	localparam int RND_SHIFT       = 32 - ANGLE_WIDTH;
	localparam int IN_TDATA_WIDTH  = ((4 * COORD_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_WIDTH = ((ANGLE_WIDTH + 7) / 8) * 8;

	typedef enum logic [1:0] {
		QUAD_MINUS_Y = 2'd0,
		QUAD_PLUS_X  = 2'd1,
		QUAD_PLUS_Y  = 2'd2,
		QUAD_MINUS_X = 2'd3
	} quad_t;

	localparam logic [31:0] ATAN_TURNS [0:31] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

endpackage

`default_nettype wire

### rtl/point_bearing_angle_top.sv
// Point bearing angle: quadrant fold, pipelined CORDIC vectoring, rounding.
// Depends on pba_pkg.
//
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          tdata: from_x, from_y, to_x, to_y
// m_axis    out  tvalid/tready          tdata: bearing; tuser: coincident
//
// One transaction per cycle while the output is not stalled; the stages are the fold
// stage, one stage per micro-rotation, and rounding into the output register.
// All stages advance together; the pipeline holds only while the output
// register is full and not taken, and s_axis_tready is low in those cycles.
// arst_n clears the valid bits; payload registers are not reset.
`default_nettype none

module point_bearing_angle_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [pba_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata,  // from_x, from_y, to_x, to_y
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic [pba_pkg::OUT_TDATA_WIDTH-1:0]      m_axis_tdata,  // bearing
	output logic                                     m_axis_tuser   // coincident
);

	localparam int CW  = pba_pkg::COORD_WIDTH;
	localparam int DW  = pba_pkg::DIFF_WIDTH;
	localparam int RW  = pba_pkg::CORDIC_WIDTH;
	localparam int ZW  = pba_pkg::ACC_WIDTH;
	localparam int AW  = pba_pkg::ANGLE_WIDTH;
	localparam int NS  = pba_pkg::STEPS;

	logic en;

	logic signed [DW-1:0] dx, dy, ndx, ndy;
	logic [CW-1:0]        u_mag, v_mag;
	pba_pkg::quad_t       quad_d;
	logic                 coin_d;

	logic signed [RW-1:0] u_s    [0:NS];
	logic signed [RW-1:0] v_s    [0:NS];
	logic signed [ZW-1:0] z_s    [0:NS];
	pba_pkg::quad_t       quad_s [0:NS];
	logic                 coin_s [0:NS];
	logic                 vld_s  [0:NS];

	logic [ZW-1:0] z_clamp;
	logic [ZW-1:0] total;
	logic [AW-1:0] bearing_d;

	logic          out_vld_q;
	logic [AW-1:0] bearing_q;
	logic          coin_q;

	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	// fold the difference vector into one quadrant
	always_comb begin
		dx = $signed({s_axis_tdata[3*CW-1], s_axis_tdata[2*CW +: CW]})
			- $signed({s_axis_tdata[CW-1], s_axis_tdata[0 +: CW]});
		dy = $signed({s_axis_tdata[4*CW-1], s_axis_tdata[3*CW +: CW]})
			- $signed({s_axis_tdata[2*CW-1], s_axis_tdata[CW +: CW]});
		ndx    = -dx;
		ndy    = -dy;
		coin_d = (dx == '0) && (dy == '0);
		if (dx > 0 && dy >= 0) begin
			quad_d = pba_pkg::QUAD_PLUS_X;
			u_mag  = dx[CW-1:0];
			v_mag  = dy[CW-1:0];
		end else if (dx <= 0 && dy > 0) begin
			quad_d = pba_pkg::QUAD_PLUS_Y;
			u_mag  = dy[CW-1:0];
			v_mag  = ndx[CW-1:0];
		end else if (dx >= 0 && dy < 0) begin
			quad_d = pba_pkg::QUAD_MINUS_Y;
			u_mag  = ndy[CW-1:0];
			v_mag  = dx[CW-1:0];
		end else begin
			quad_d = pba_pkg::QUAD_MINUS_X;
			u_mag  = ndx[CW-1:0];
			v_mag  = ndy[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s[0]    <= $signed({{pba_pkg::HEAD_PAD{1'b0}}, u_mag,
				{pba_pkg::SHIFT_UP{1'b0}}});
			v_s[0]    <= $signed({{pba_pkg::HEAD_PAD{1'b0}}, v_mag,
				{pba_pkg::SHIFT_UP{1'b0}}});
			z_s[0]    <= '0;
			quad_s[0] <= quad_d;
			coin_s[0] <= coin_d;
		end
	end

	// one micro-rotation per stage
	for (genvar k = 0; k < NS; k++) begin : g_rot
		logic signed [RW-1:0] sh_u, sh_v;
		logic signed [ZW-1:0] t_k;

		assign sh_u = u_s[k] >>> k;
		assign sh_v = v_s[k] >>> k;
		assign t_k  = $signed({{(ZW-32){1'b0}}, pba_pkg::ATAN_TURNS[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (v_s[k][RW-1]) begin
					u_s[k+1] <= u_s[k] - sh_v;
					v_s[k+1] <= v_s[k] + sh_u;
					z_s[k+1] <= z_s[k] - t_k;
				end else if (v_s[k] != '0) begin
					u_s[k+1] <= u_s[k] + sh_v;
					v_s[k+1] <= v_s[k] - sh_u;
					z_s[k+1] <= z_s[k] + t_k;
				end else begin
					u_s[k+1] <= u_s[k];
					v_s[k+1] <= v_s[k];
					z_s[k+1] <= z_s[k];
				end
				quad_s[k+1] <= quad_s[k];
				coin_s[k+1] <= coin_s[k];
			end
		end
	end

	// clamp, add quadrant base, round
	always_comb begin
		if (z_s[NS][ZW-1]) begin
			z_clamp = '0;
		end else if (z_s[NS] > $signed(ZW'(1) << 30)) begin
			z_clamp = ZW'(1) << 30;
		end else begin
			z_clamp = z_s[NS];
		end
		total = (ZW'(quad_s[NS]) << 30) + z_clamp;
	end

	if (pba_pkg::RND_SHIFT > 0) begin : g_rnd
		logic [ZW-1:0] rnd;
		assign rnd       = total + (ZW'(1) << (pba_pkg::RND_SHIFT - 1));
		assign bearing_d = rnd[pba_pkg::RND_SHIFT +: AW];
	end else begin : g_nornd
		assign bearing_d = total[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bearing_q <= coin_s[NS] ? '0 : bearing_d;
			coin_q    <= coin_s[NS];
		end
	end

	always_comb begin
		m_axis_tdata           = '0;
		m_axis_tdata[AW-1:0]   = bearing_q;
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tuser  = coin_q;

endmodule

`default_nettype wire

### rtl/pba_checker.sv
// Port-level checks for point_bearing_angle_top, attached by bind.
// Depends on pba_pkg and point_bearing_angle_top.
`default_nettype none

module pba_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                s_axis_tready,
	input wire logic                                m_axis_tvalid,
	input wire logic                                m_axis_tready,
	input wire logic [pba_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
	input wire logic                                m_axis_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled output payload changed");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input accepted while pipeline stalled");

	a_coincident_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("coincident result with nonzero bearing");

	a_rise_after_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tready))
		else $error("output appeared without pipeline advance");

endmodule

bind point_bearing_angle_top pba_checker u_pba_checker (.*);

`default_nettype wire
